FILE: rtl/bcsp_pkg.sv
`timescale 1ns / 1ps

package bcsp_pkg;

  // field widths of the stream items
  localparam int unsigned NodeW  = 7;
  localparam int unsigned PriceW = 16;
  localparam int unsigned CostW  = 16;

  // default sizes of the stores
  localparam int unsigned MaxNodesDef = 128;
  localparam int unsigned MaxEdgesDef = 1024;

  // budget register value after reset
  localparam logic [CostW-1:0] BudgetReset = 16'd60000;

  // request codes carried in the lowest tdata bits
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_NODE_RD,
    S_RELAX_AB,
    S_RELAX_BA,
    S_FIN_RD,
    S_FIN,
    S_EMIT
  } state_e;

  // one stored edge
  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [NodeW-1:0]  node_b;
    logic [NodeW-1:0]  node_a;
  } edge_t;

  // one entry of the per-node cost memory
  typedef struct packed {
    logic             reached;
    logic [CostW-1:0] cost;
  } cost_ent_t;

endpackage

FILE: rtl/budget_capped_shortest_path.sv
`timescale 1ns / 1ps

// Budget-capped shortest path engine. Edges are loaded one per transaction
// (req_type add) into an edge memory of MAX_EDGES entries and can be travelled
// both ways; clear empties it and resets the sticky edges_dropped flag, which
// is set when an in-range edge arrives with the memory full. Clear and add
// produce no result. A query from node_a to node_b returns one result: found
// and the least path price not above the budget register. A query whose nodes
// are equal, or lie outside the node range, answers without a search. Any
// other query first initializes the per-node cost memory, then relaxes every
// stored edge in both directions, one read-modify-write of the cost memory per
// direction, repeating rounds until one round changes nothing or MAX_NODES
// rounds have run, and then reads the cost of node_b and answers. No new
// transaction is taken while a query runs. The budget is written through
// cfg_we_i and must only change while the block is idle.
module budget_capped_shortest_path import bcsp_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned MAX_EDGES = MaxEdgesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_type[1:0], node_a[8:2], node_b[15:9], price[31:16]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // found[0], cost[16:1], edges_dropped[17], zero[23:18]
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned RW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);

  // request fields
  req_e             req;
  edge_t            in_edge;
  logic             in_acc;

  assign req             = req_e'(s_axis_tdata[1:0]);
  assign in_edge.node_a  = s_axis_tdata[8:2];
  assign in_edge.node_b  = s_axis_tdata[15:9];
  assign in_edge.price   = s_axis_tdata[31:16];
  assign in_acc          = s_axis_tvalid && s_axis_tready;

  // registers
  state_e           state_q, state_d;
  logic [NW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    edge_idx_q, edge_idx_d;
  logic [RW-1:0]    round_q, round_d;
  logic             changed_q, changed_d;
  logic [NW-1:0]    src_q, src_d;
  logic [NW-1:0]    dst_q, dst_d;
  edge_t            edge_q, edge_d;
  cost_ent_t        ent_a_q, ent_a_d;
  cost_ent_t        ent_b_q, ent_b_d;
  logic             pend_found_q, pend_found_d;
  logic [CostW-1:0] pend_cost_q, pend_cost_d;
  logic             drop_q, drop_d;
  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [CostW-1:0] out_cost_q, out_cost_d;
  logic             out_drop_q, out_drop_d;
  logic [CostW-1:0] budget_q;

  // edge store signals
  logic             es_clear;
  logic             es_add;
  edge_t            es_rd_edge;
  logic [CW-1:0]    es_count;
  logic             es_overflow;

  // cost memory signals
  logic             cm_we;
  logic [NW-1:0]    cm_waddr;
  cost_ent_t        cm_wdata;
  logic [NW-1:0]    cm_raddr0;
  logic [NW-1:0]    cm_raddr1;
  cost_ent_t        cm_rdata0;
  cost_ent_t        cm_rdata1;

  // relaxation arithmetic
  logic [CostW:0]   cand_ab;
  logic [CostW:0]   cand_ba;
  logic             upd_ab;
  logic             upd_ba;
  logic             q_out_range;
  logic [CW-1:0]    edge_next;

  bcsp_edge_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (es_clear),
    .add_i      (es_add),
    .edge_i     (in_edge),
    .rd_addr_i  (edge_idx_d[AW-1:0]),
    .rd_edge_o  (es_rd_edge),
    .count_o    (es_count),
    .overflow_o (es_overflow)
  );

  bcsp_cost_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_cost_mem (
    .clk_i    (clk_i),
    .we_i     (cm_we),
    .waddr_i  (cm_waddr),
    .wdata_i  (cm_wdata),
    .raddr0_i (cm_raddr0),
    .raddr1_i (cm_raddr1),
    .rdata0_o (cm_rdata0),
    .rdata1_o (cm_rdata1)
  );

  // budget register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BudgetReset;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign es_clear      = in_acc && (req == REQ_CLEAR);
  assign es_add        = in_acc && (req == REQ_ADD);

  assign q_out_range = (32'(in_edge.node_a) >= 32'(MAX_NODES)) ||
                       (32'(in_edge.node_b) >= 32'(MAX_NODES));

  // a to b uses the fresh memory read, b to a the updated copies
  assign cand_ab = {1'b0, cm_rdata0.cost} + {1'b0, edge_q.price};
  assign upd_ab  = cm_rdata0.reached && (cand_ab <= {1'b0, budget_q}) &&
                   (!cm_rdata1.reached || ({1'b0, cm_rdata1.cost} > cand_ab));
  assign cand_ba = {1'b0, ent_b_q.cost} + {1'b0, edge_q.price};
  assign upd_ba  = ent_b_q.reached && (cand_ba <= {1'b0, budget_q}) &&
                   (!ent_a_q.reached || ({1'b0, ent_a_q.cost} > cand_ba));

  assign edge_next = edge_idx_q + CW'(1);

  // sequencer next state and datapath
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    edge_idx_d   = edge_idx_q;
    round_d      = round_q;
    changed_d    = changed_q;
    src_d        = src_q;
    dst_d        = dst_q;
    edge_d       = edge_q;
    ent_a_d      = ent_a_q;
    ent_b_d      = ent_b_q;
    pend_found_d = pend_found_q;
    pend_cost_d  = pend_cost_q;
    drop_d       = drop_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_found_d  = out_found_q;
    out_cost_d   = out_cost_q;
    out_drop_d   = out_drop_q;
    cm_we        = 1'b0;
    cm_waddr     = idx_q;
    cm_wdata     = '0;
    cm_raddr0    = dst_q;
    cm_raddr1    = dst_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (req == REQ_QUERY)) begin
          drop_d       = es_overflow;
          pend_found_d = 1'b0;
          pend_cost_d  = '0;
          src_d        = NW'(in_edge.node_a);
          dst_d        = NW'(in_edge.node_b);
          idx_d        = '0;
          if (in_edge.node_a == in_edge.node_b) begin
            pend_found_d = 1'b1;
            state_d      = S_EMIT;
          end else if (q_out_range) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_SWEEP;
          end
        end
      end

      // initialize every node, only the start node reached at cost zero
      S_SWEEP: begin
        cm_we            = 1'b1;
        cm_waddr         = idx_q;
        cm_wdata.reached = (idx_q == src_q);
        cm_wdata.cost    = '0;
        if (idx_q == NW'(MAX_NODES - 1)) begin
          round_d    = '0;
          changed_d  = 1'b0;
          edge_idx_d = '0;
          state_d    = (es_count == '0) ? S_FIN_RD : S_NODE_RD;
        end else begin
          idx_d = idx_q + NW'(1);
        end
      end

      // edge data is valid, fetch both endpoint costs
      S_NODE_RD: begin
        edge_d    = es_rd_edge;
        cm_raddr0 = NW'(es_rd_edge.node_a);
        cm_raddr1 = NW'(es_rd_edge.node_b);
        state_d   = S_RELAX_AB;
      end

      S_RELAX_AB: begin
        ent_a_d = cm_rdata0;
        ent_b_d = cm_rdata1;
        if (upd_ab) begin
          cm_we           = 1'b1;
          cm_waddr        = NW'(edge_q.node_b);
          cm_wdata        = {1'b1, cand_ab[CostW-1:0]};
          ent_b_d         = {1'b1, cand_ab[CostW-1:0]};
          changed_d       = 1'b1;
        end
        state_d = S_RELAX_BA;
      end

      S_RELAX_BA: begin
        if (upd_ba) begin
          cm_we     = 1'b1;
          cm_waddr  = NW'(edge_q.node_a);
          cm_wdata  = {1'b1, cand_ba[CostW-1:0]};
          changed_d = 1'b1;
        end
        if (edge_next == es_count) begin
          // end of a round
          if (!(changed_q || upd_ba) || (round_q + RW'(1) == RW'(MAX_NODES))) begin
            state_d = S_FIN_RD;
          end else begin
            round_d    = round_q + RW'(1);
            changed_d  = 1'b0;
            edge_idx_d = '0;
            state_d    = S_NODE_RD;
          end
        end else begin
          edge_idx_d = edge_next;
          state_d    = S_NODE_RD;
        end
      end

      S_FIN_RD: begin
        cm_raddr0 = dst_q;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (cm_rdata0.reached && (cm_rdata0.cost <= budget_q)) begin
          pend_found_d = 1'b1;
          pend_cost_d  = cm_rdata0.cost;
        end
        state_d = S_EMIT;
      end

      // hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_found_d = pend_found_q;
          out_cost_d  = pend_cost_q;
          out_drop_d  = drop_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      edge_idx_q  <= '0;
      round_q     <= '0;
      changed_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      edge_idx_q  <= edge_idx_d;
      round_q     <= round_d;
      changed_q   <= changed_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    dst_q        <= dst_d;
    edge_q       <= edge_d;
    ent_a_q      <= ent_a_d;
    ent_b_q      <= ent_b_d;
    pend_found_q <= pend_found_d;
    pend_cost_q  <= pend_cost_d;
    drop_q       <= drop_d;
    out_found_q  <= out_found_d;
    out_cost_q   <= out_cost_d;
    out_drop_q   <= out_drop_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_drop_q, out_cost_q, out_found_q};

endmodule

FILE: rtl/bcsp_edge_store.sv
`timescale 1ns / 1ps

module bcsp_edge_store import bcsp_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned MAX_EDGES = MaxEdgesDef,
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int unsigned CW = $clog2(MAX_EDGES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          add_i,
  input  edge_t         edge_i,
  input  logic [AW-1:0] rd_addr_i,
  output edge_t         rd_edge_o,
  output logic [CW-1:0] count_o,
  output logic          overflow_o
);

  edge_t         mem_q [MAX_EDGES];
  logic [CW-1:0] count_q, count_d;
  logic          overflow_q, overflow_d;
  logic          in_range;
  logic          full;
  logic          wr_en;

  // endpoints must lie inside the node range
  assign in_range = (32'(edge_i.node_a) < 32'(MAX_NODES)) &&
                    (32'(edge_i.node_b) < 32'(MAX_NODES));
  assign full     = (count_q == CW'(MAX_EDGES));
  assign wr_en    = add_i && in_range && !full;

  // fill count and sticky drop flag
  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (clear_i) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end else if (add_i && in_range) begin
      if (full) begin
        overflow_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
    end
  end

  // edge memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= edge_i;
    end
    rd_edge_o <= mem_q[rd_addr_i];
  end

  assign count_o    = count_q;
  assign overflow_o = overflow_q;

endmodule

FILE: rtl/bcsp_cost_mem.sv
`timescale 1ns / 1ps

module bcsp_cost_mem import bcsp_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  localparam int unsigned NW = $clog2(MAX_NODES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [NW-1:0] waddr_i,
  input  cost_ent_t     wdata_i,
  input  logic [NW-1:0] raddr0_i,
  input  logic [NW-1:0] raddr1_i,
  output cost_ent_t     rdata0_o,
  output cost_ent_t     rdata1_o
);

  cost_ent_t mem_q [MAX_NODES];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

FILE: verif/budget_capped_shortest_path_test.sv
`timescale 1ns / 1ps

module budget_capped_shortest_path_test;
  import bcsp_pkg::*;

  localparam int unsigned NodeCnt        = MaxNodesDef;
  localparam int unsigned EdgeCap        = MaxEdgesDef;
  // a full edge store relaxed over every round, plus a long receiver stall
  localparam int unsigned WatchdogLimit  = 2000000;
  localparam int unsigned LongHoldCycles = 3000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned RandomPerPhase = 140;
  localparam logic [1:0]  ReqUnused      = 2'd3;

  // request layout as in s_axis_tdata, highest field first
  typedef struct packed {
    logic [15:0] price;
    logic [6:0]  node_b;
    logic [6:0]  node_a;
    logic [1:0]  req;
  } request_t;

  // result layout as in m_axis_tdata
  typedef struct packed {
    logic [5:0]  pad;
    logic        dropped;
    logic [15:0] cost;
    logic        found;
  } route_answer_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_SPARSE
  } rx_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  budget_capped_shortest_path i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // requests waiting to be sent and answers waiting to arrive
  request_t      request_q[$];
  route_answer_t answer_q[$];

  // graph mirror
  logic [6:0]  graph_a [EdgeCap];
  logic [6:0]  graph_b [EdgeCap];
  logic [15:0] graph_w [EdgeCap];
  int unsigned graph_count   = 0;
  logic        graph_dropped = 1'b0;
  logic [15:0] budget_q      = BudgetReset;

  int unsigned mismatch_count = 0;
  int unsigned gen_edges      = 0;
  int unsigned hold_token     = 0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // least budget-capped path price by repeated relaxation of both directions
  function automatic route_answer_t solve_route(input logic [6:0] src, input logic [6:0] dst);
    route_answer_t ans;
    int unsigned   path_cost [NodeCnt];
    bit            reached [NodeCnt];
    bit            changed;
    int unsigned   cand;
    logic [6:0]    tail;
    logic [6:0]    head;
    ans         = '0;
    ans.dropped = graph_dropped;
    if (src == dst) begin
      ans.found = 1'b1;
      return ans;
    end
    for (int n = 0; n < NodeCnt; n++) begin
      path_cost[n] = 0;
      reached[n]   = 1'b0;
    end
    reached[src] = 1'b1;
    for (int r = 0; r < NodeCnt; r++) begin
      changed = 1'b0;
      for (int i = 0; i < graph_count; i++) begin
        for (int dir = 0; dir < 2; dir++) begin
          tail = dir ? graph_b[i] : graph_a[i];
          head = dir ? graph_a[i] : graph_b[i];
          if (reached[tail]) begin
            cand = path_cost[tail] + graph_w[i];
            if (cand <= budget_q && (!reached[head] || path_cost[head] > cand)) begin
              path_cost[head] = cand;
              reached[head]   = 1'b1;
              changed         = 1'b1;
            end
          end
        end
      end
      if (!changed) break;
    end
    if (reached[dst] && path_cost[dst] <= budget_q) begin
      ans.found = 1'b1;
      ans.cost  = path_cost[dst][15:0];
    end
    return ans;
  endfunction

  // update the graph mirror with one accepted request
  task automatic absorb_request(input request_t rq);
    case (rq.req)
      REQ_CLEAR: begin
        graph_count   = 0;
        graph_dropped = 1'b0;
      end
      REQ_ADD: begin
        if (graph_count >= EdgeCap) begin
          graph_dropped = 1'b1;
        end else begin
          graph_a[graph_count] = rq.node_a;
          graph_b[graph_count] = rq.node_b;
          graph_w[graph_count] = rq.price;
          graph_count++;
        end
      end
      REQ_QUERY: answer_q = {answer_q, solve_route(rq.node_a, rq.node_b)};
      default: ;
    endcase
  endtask

  // compare one result transaction with the oldest expected answer
  task automatic check_answer(input route_answer_t got);
    route_answer_t want;
    if (answer_q.size() == 0) begin
      $error("result with no query pending: tdata %h", got);
      mismatch_count++;
    end else begin
      want = answer_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatch_count++;
      end
      if (got.cost !== want.cost) begin
        $error("cost: expected %0d, got %0d", want.cost, got.cost);
        mismatch_count++;
      end
      if (got.dropped !== want.dropped) begin
        $error("edges_dropped: expected %0d, got %0d", want.dropped, got.dropped);
        mismatch_count++;
      end
    end
  endtask

  // request driver, bursts with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  logic        drv_valid;
  request_t    drv_item;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      drv_valid = s_axis_tvalid;
      drv_item  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_request(s_axis_tdata);
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          drv_item  = request_q.pop_front();
          drv_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 400);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 8);
          end
        end
      end
      s_axis_tvalid <= drv_valid;
      s_axis_tdata  <= drv_item;
    end
  end

  // result monitor with its own stall pattern and the long hold-off
  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_phase     = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_served  = 0;
  logic        rx_ready;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_answer(m_axis_tdata);
      if (hold_served != hold_token) begin
        hold_served = hold_token;
        hold_left   = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(32, 256);
        end else begin
          rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
          RX_OPEN:   rx_ready = 1'b1;
          RX_COIN:   rx_ready = $urandom_range(0, 1);
          RX_EVERY4: rx_ready = (rx_phase % 4 == 0);
          default:   rx_ready = ($urandom_range(0, 9) == 0);
        endcase
      end
      m_axis_tready <= rx_ready;
    end
  end

  // watchdog on cycles with no transaction on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic void queue_request(input logic [1:0] kind, input int unsigned a,
                                        input int unsigned b, input int unsigned p);
    request_t rq;
    rq.req    = kind;
    rq.node_a = a[6:0];
    rq.node_b = b[6:0];
    rq.price  = p[15:0];
    request_q = {request_q, rq};
  endfunction

  // mostly cheap edges so the budget decides, with some extremes
  function automatic int unsigned draw_price();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 16'hFFFF;
      2, 3:    return $urandom_range(0, 65535);
      4:       return $urandom_range(0, budget_q);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // usually a clear, a small local graph, then queries into it; some raw noise
  task automatic queue_random_traffic(input int unsigned target);
    int unsigned n_items;
    int unsigned span;
    int unsigned base;
    int unsigned a;
    int unsigned b;
    request_t    rq;
    n_items = 0;
    while (n_items < target) begin
      if ($urandom_range(0, 99) < 85) begin
        if (gen_edges > 40 || $urandom_range(0, 4) != 0) begin
          queue_request(REQ_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 65535));
          gen_edges = 0;
          n_items++;
        end
        span = ($urandom_range(0, 9) == 0) ? 127 : $urandom_range(1, 12);
        base = $urandom_range(0, 127 - span);
        repeat ($urandom_range(0, 12)) begin
          queue_request(REQ_ADD, base + $urandom_range(0, span),
                        base + $urandom_range(0, span), draw_price());
          gen_edges++;
          n_items++;
        end
        repeat ($urandom_range(1, 5)) begin
          a = base + $urandom_range(0, span);
          b = ($urandom_range(0, 6) == 0) ? a : base + $urandom_range(0, span);
          if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 127);
          queue_request(REQ_QUERY, a, b, $urandom_range(0, 65535));
          n_items++;
        end
      end else begin
        rq = request_t'($urandom);
        request_q = {request_q, rq};
        if (rq.req == REQ_CLEAR) gen_edges = 0;
        if (rq.req == REQ_ADD) gen_edges++;
        if (rq.req != ReqUnused) n_items++;
      end
    end
  endtask

  // sender pause until every answer is in and the block has settled
  task automatic wait_for_quiet();
    @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_budget(input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    budget_q = value;
    @(negedge clk_i);
  endtask

  // stimulus sequence
  logic [15:0] phase_budget [6];

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty graph, both directions, budget edge, self loop, clear
    queue_request(REQ_QUERY, 5, 5, 0);
    queue_request(REQ_QUERY, 0, 127, 0);
    queue_request(REQ_ADD, 0, 1, 100);
    queue_request(REQ_ADD, 1, 2, 200);
    queue_request(REQ_ADD, 2, 127, 16'hFFFF);
    queue_request(REQ_ADD, 0, 2, 500);
    queue_request(REQ_QUERY, 0, 2, 0);
    queue_request(REQ_QUERY, 2, 0, 16'hFFFF);
    queue_request(REQ_QUERY, 0, 127, 0);
    queue_request(ReqUnused, 127, 127, 16'hFFFF);
    queue_request(REQ_ADD, 127, 3, 0);
    queue_request(REQ_ADD, 9, 9, 7);
    queue_request(REQ_ADD, 5, 6, 60000);
    queue_request(REQ_QUERY, 5, 6, 0);
    queue_request(REQ_QUERY, 127, 127, 0);
    queue_request(REQ_CLEAR, 0, 0, 0);
    queue_request(REQ_QUERY, 0, 2, 0);
    wait_for_quiet();

    // zero budget: only free edges count
    write_budget(16'd0);
    queue_request(REQ_ADD, 5, 6, 0);
    queue_request(REQ_ADD, 6, 7, 1);
    queue_request(REQ_QUERY, 6, 5, 0);
    queue_request(REQ_QUERY, 5, 7, 0);
    queue_request(REQ_QUERY, 7, 7, 0);
    wait_for_quiet();

    // fill the edge store past its end, then clear the sticky flag
    write_budget(16'hFFFF);
    queue_request(REQ_CLEAR, 0, 0, 0);
    repeat (EdgeCap + 2) begin
      queue_request(REQ_ADD, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 65535));
    end
    queue_request(REQ_QUERY, 0, 7, 0);
    queue_request(REQ_QUERY, 100, 0, 0);
    queue_request(REQ_QUERY, 4, 4, 0);
    queue_request(REQ_CLEAR, 0, 0, 0);
    queue_request(REQ_QUERY, 0, 1, 0);
    wait_for_quiet();

    // receiver holds off while queries keep coming
    write_budget(16'd1000);
    hold_token++;
    queue_request(REQ_CLEAR, 0, 0, 0);
    queue_request(REQ_ADD, 0, 1, 10);
    queue_request(REQ_ADD, 1, 2, 20);
    queue_request(REQ_ADD, 2, 3, 30);
    repeat (40) queue_request(REQ_QUERY, $urandom_range(0, 4), $urandom_range(0, 4), 0);
    wait_for_quiet();
    gen_edges = 0;

    // random traffic over several budget settings
    phase_budget[0] = 16'd60000;
    phase_budget[1] = 16'hFFFF;
    phase_budget[2] = $urandom_range(20, 3000);
    phase_budget[3] = 16'd0;
    phase_budget[4] = $urandom_range(0, 65535);
    phase_budget[5] = 16'd60000;
    foreach (phase_budget[p]) begin
      write_budget(phase_budget[p]);
      queue_random_traffic(RandomPerPhase);
      wait_for_quiet();
    end

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
